// File: rtl/core/hsv_to_rgb_converter_defines.svh
// Assertion macros for the HSV to RGB converter checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// Same-cycle implication, held off during reset
`define HSV2RGB_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset
`define HSV2RGB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must hold in the cycle after reset is seen
`define HSV2RGB_ASSERT_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/hsv2rgb_pkg.sv
// Shared types, constants and helper functions of the HSV to RGB converter.
// No dependencies; used by the front, mid queue, back and top level.
`default_nettype none

package hsv2rgb_pkg;

   // Hue sector codes, one per sixth of the hue circle
   localparam logic [2:0] SEC_RED_YEL = 3'd0;
   localparam logic [2:0] SEC_YEL_GRN = 3'd1;
   localparam logic [2:0] SEC_GRN_CYN = 3'd2;
   localparam logic [2:0] SEC_CYN_BLU = 3'd3;
   localparam logic [2:0] SEC_BLU_MAG = 3'd4;
   localparam logic [2:0] SEC_MAG_RED = 3'd5;

   localparam logic [7:0]  LEVEL_MAX = 8'd255;
   localparam logic [16:0] FRAC_ONE  = 17'h10000;
   // 255 * 65536: full scale of the ramp numerators
   localparam logic [23:0] RAMP_FULL = 24'hFF0000;

   // Item leaving the front: clamped levels, sector and fraction
   typedef struct packed {
      logic [7:0]  sat;
      logic [7:0]  val;
      logic [2:0]  sector;
      logic [15:0] frac;
      logic [7:0]  alpha;
   } front_item_type;

   // First back stage: scaled saturation terms and floor numerator
   typedef struct packed {
      logic [7:0]  val;
      logic [2:0]  sector;
      logic [7:0]  alpha;
      logic [23:0] sat_frac;
      logic [23:0] sat_cofrac;
      logic [15:0] floor_num;
   } stage_a_type;

   // Second back stage: ramp quotients by 65536, floor level done
   typedef struct packed {
      logic [7:0]  val;
      logic [2:0]  sector;
      logic [7:0]  alpha;
      logic [15:0] fall_num;
      logic [15:0] rise_num;
      logic [7:0]  floor_lvl;
   } stage_b_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rgba_type;

   // Head status of the mid queue as the back sees it
   typedef struct packed {
      logic valid;
   } link_type;

   // Exact floor(x / 255) for x up to 255*255 + 254
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [15:0] sum;
      begin
         sum = x + {8'd0, x[15:8]} + 16'd1;
         return sum[15:8];
      end
   endfunction

   // Clamp a signed 10-bit level to 0..255
   function automatic logic [7:0] clamp_level(input logic signed [9:0] raw);
      begin
         if (raw[9]) begin
            return 8'd0;
         end else if (raw[8]) begin
            return LEVEL_MAX;
         end else begin
            return raw[7:0];
         end
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/hsv2rgb_front.sv
// Front of the HSV to RGB converter: accepts items, clamps levels, splits hue.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic [15:0]                 req_hue_frac,
   input  wire logic signed [9:0]           req_sat_level,
   input  wire logic signed [9:0]           req_val_level,
   input  wire logic [7:0]                  req_alpha_in,
   input  wire logic                        queue_full,
   output logic                             queue_push,
   output hsv2rgb_pkg::front_item_type      queue_item
);

   logic                         valid_ff;
   logic                         valid_in;
   hsv2rgb_pkg::front_item_type  item_ff;
   hsv2rgb_pkg::front_item_type  item_in;
   logic [18:0]                  hue6;
   logic                         accept;

   // Hand the held item on whenever the queue has room
   assign queue_push = valid_ff && !queue_full;
   assign req_full   = valid_ff && queue_full;
   assign accept     = req_push && !req_full;
   assign queue_item = item_ff;

   // Scale hue by six: sector in the integer part, fraction below
   always_comb begin
      hue6           = {1'b0, req_hue_frac, 2'b00} + {2'b00, req_hue_frac, 1'b0};
      item_in.sat    = hsv2rgb_pkg::clamp_level(req_sat_level);
      item_in.val    = hsv2rgb_pkg::clamp_level(req_val_level);
      item_in.sector = hue6[18:16];
      item_in.frac   = hue6[15:0];
      item_in.alpha  = req_alpha_in;
      valid_in       = accept || (valid_ff && !queue_push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load a new item when accepted; otherwise hold
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/hsv2rgb_queue.sv
// Two-entry queue that decouples the front from the back.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire hsv2rgb_pkg::front_item_type push_item,
   output logic                             full,
   output hsv2rgb_pkg::link_type            head_link,
   input  wire logic                        pop,
   output hsv2rgb_pkg::front_item_type      head_item
);

   hsv2rgb_pkg::front_item_type  slot_ff [2];
   logic                         wr_ptr_ff;
   logic                         wr_ptr_in;
   logic                         rd_ptr_ff;
   logic                         rd_ptr_in;
   logic [1:0]                   count_ff;
   logic [1:0]                   count_in;
   logic                         do_pop;

   assign full            = count_ff[1];
   assign head_link.valid = count_ff != 2'd0;
   assign do_pop          = pop && head_link.valid;
   assign head_item       = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/hsv2rgb_back.sv
// Back of the HSV to RGB converter: two multiply stages, divide by 255,
// sector mux and a two-entry result queue. Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire hsv2rgb_pkg::link_type       head_link,
   input  wire hsv2rgb_pkg::front_item_type head_item,
   output logic                             head_pop,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output hsv2rgb_pkg::rgba_type            rsp_item
);

   hsv2rgb_pkg::stage_a_type  a_ff;
   hsv2rgb_pkg::stage_a_type  a_in;
   hsv2rgb_pkg::stage_b_type  b_ff;
   hsv2rgb_pkg::stage_b_type  b_in;
   hsv2rgb_pkg::rgba_type     res_in;
   hsv2rgb_pkg::rgba_type     out_ff [2];
   logic                      a_valid_ff;
   logic                      a_valid_in;
   logic                      b_valid_ff;
   logic                      b_valid_in;
   logic                      out_wr_ff;
   logic                      out_rd_ff;
   logic [1:0]                out_count_ff;
   logic [1:0]                out_count_in;
   logic                      a_load;
   logic                      b_load;
   logic                      out_write;
   logic                      out_read;
   logic [16:0]               cofrac;
   logic [31:0]               fall_prod;
   logic [31:0]               rise_prod;
   logic [7:0]                fall_lvl;
   logic [7:0]                rise_lvl;

   // Stall chain: each stage moves when the next can take it
   assign out_write = b_valid_ff && !out_count_ff[1];
   assign b_load    = a_valid_ff && (!b_valid_ff || out_write);
   assign a_load    = head_link.valid && (!a_valid_ff || b_load);
   assign head_pop  = a_load;
   assign out_read  = rsp_pop && !rsp_empty;
   assign rsp_empty = out_count_ff == 2'd0;
   assign rsp_item  = out_ff[out_rd_ff];

   // Stage A: saturation times fraction and co-fraction, floor numerator
   always_comb begin
      cofrac          = hsv2rgb_pkg::FRAC_ONE - {1'b0, head_item.frac};
      a_in.val        = head_item.val;
      a_in.sector     = head_item.sector;
      a_in.alpha      = head_item.alpha;
      a_in.sat_frac   = {16'd0, head_item.sat} * {8'd0, head_item.frac};
      a_in.sat_cofrac = 24'({17'd0, head_item.sat} * {8'd0, cofrac});
      a_in.floor_num  = {8'd0, head_item.val} *
                        ({8'd0, hsv2rgb_pkg::LEVEL_MAX} - {8'd0, head_item.sat});
   end

   // Stage B: value times ramp numerators, keep quotient by 65536
   always_comb begin
      fall_prod      = {24'd0, a_ff.val} *
                       ({8'd0, hsv2rgb_pkg::RAMP_FULL} - {8'd0, a_ff.sat_frac});
      rise_prod      = {24'd0, a_ff.val} *
                       ({8'd0, hsv2rgb_pkg::RAMP_FULL} - {8'd0, a_ff.sat_cofrac});
      b_in.val       = a_ff.val;
      b_in.sector    = a_ff.sector;
      b_in.alpha     = a_ff.alpha;
      b_in.fall_num  = fall_prod[31:16];
      b_in.rise_num  = rise_prod[31:16];
      b_in.floor_lvl = hsv2rgb_pkg::div255(a_ff.floor_num);
   end

   // Finish the ramps and route levels to channels by sector
   always_comb begin
      fall_lvl     = hsv2rgb_pkg::div255(b_ff.fall_num);
      rise_lvl     = hsv2rgb_pkg::div255(b_ff.rise_num);
      res_in.alpha = b_ff.alpha;
      case (b_ff.sector)
         hsv2rgb_pkg::SEC_RED_YEL: begin
            res_in.red   = b_ff.val;
            res_in.green = rise_lvl;
            res_in.blue  = b_ff.floor_lvl;
         end
         hsv2rgb_pkg::SEC_YEL_GRN: begin
            res_in.red   = fall_lvl;
            res_in.green = b_ff.val;
            res_in.blue  = b_ff.floor_lvl;
         end
         hsv2rgb_pkg::SEC_GRN_CYN: begin
            res_in.red   = b_ff.floor_lvl;
            res_in.green = b_ff.val;
            res_in.blue  = rise_lvl;
         end
         hsv2rgb_pkg::SEC_CYN_BLU: begin
            res_in.red   = b_ff.floor_lvl;
            res_in.green = fall_lvl;
            res_in.blue  = b_ff.val;
         end
         hsv2rgb_pkg::SEC_BLU_MAG: begin
            res_in.red   = rise_lvl;
            res_in.green = b_ff.floor_lvl;
            res_in.blue  = b_ff.val;
         end
         default: begin
            res_in.red   = b_ff.val;
            res_in.green = b_ff.floor_lvl;
            res_in.blue  = fall_lvl;
         end
      endcase
   end

   // Stage valid bits and result queue occupancy
   always_comb begin
      a_valid_in   = a_load || (a_valid_ff && !b_load);
      b_valid_in   = b_load || (b_valid_ff && !out_write);
      out_count_in = out_count_ff + {1'b0, out_write} - {1'b0, out_read};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_wr_ff    <= 1'b0;
         out_rd_ff    <= 1'b0;
         out_count_ff <= 2'd0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         out_wr_ff    <= out_wr_ff ^ out_write;
         out_rd_ff    <= out_rd_ff ^ out_read;
         out_count_ff <= out_count_in;
      end
   end

   // Payload registers load only when their stage advances
   always_ff @(posedge clock) begin
      if (a_load) begin
         a_ff <= a_in;
      end
      if (b_load) begin
         b_ff <= b_in;
      end
      if (out_write) begin
         out_ff[out_wr_ff] <= res_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: front, mid queue and back.
// Depends on hsv2rgb_pkg, hsv2rgb_front, hsv2rgb_queue, hsv2rgb_back.
//
//   channel   handshake         accepted when         payload
//   request   req_push/req_full req_push & !req_full  hue, sat, val, alpha
//   response  rsp_pop/rsp_empty rsp_pop & !rsp_empty  red, green, blue, alpha
//
// One item per clock sustained while the response side keeps popping; the multiplier stages are fully pipelined.
// An accepted item passes in order through the front register, mid queue,
// two multiply stages and the result queue before it shows on the response ports.
// Reset (synchronous) empties every stage; the payload registers are not reset.
// A stalled response side fills the result queue, then the stages and the
// mid queue; req_full rises only once the front register cannot drain.
`default_nettype none

module hsv_to_rgb_converter (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [15:0]       req_hue_frac,
   input  wire logic signed [9:0] req_sat_level,
   input  wire logic signed [9:0] req_val_level,
   input  wire logic [7:0]        req_alpha_in,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [7:0]             rsp_red_out,
   output logic [7:0]             rsp_green_out,
   output logic [7:0]             rsp_blue_out,
   output logic [7:0]             rsp_alpha_out
);

   hsv2rgb_pkg::front_item_type  front_item;
   hsv2rgb_pkg::front_item_type  head_item;
   hsv2rgb_pkg::link_type        head_link;
   hsv2rgb_pkg::rgba_type        rsp_item;
   logic                         queue_push;
   logic                         queue_full;
   logic                         head_pop;

   hsv2rgb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_hue_frac  (req_hue_frac),
      .req_sat_level (req_sat_level),
      .req_val_level (req_val_level),
      .req_alpha_in  (req_alpha_in),
      .queue_full    (queue_full),
      .queue_push    (queue_push),
      .queue_item    (front_item)
   );

   hsv2rgb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_item (front_item),
      .full      (queue_full),
      .head_link (head_link),
      .pop       (head_pop),
      .head_item (head_item)
   );

   hsv2rgb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_link (head_link),
      .head_item (head_item),
      .head_pop  (head_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   assign rsp_red_out   = rsp_item.red;
   assign rsp_green_out = rsp_item.green;
   assign rsp_blue_out  = rsp_item.blue;
   assign rsp_alpha_out = rsp_item.alpha;

endmodule

`default_nettype wire

// File: rtl/core/hsv2rgb_checker.sv
// Port-level checker for the HSV to RGB converter, bound to the top level.
// Depends on hsv_to_rgb_converter_defines.svh and hsv_to_rgb_converter.
`default_nettype none
`include "hsv_to_rgb_converter_defines.svh"

module hsv2rgb_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_push,
   input wire logic              req_full,
   input wire logic [15:0]       req_hue_frac,
   input wire logic signed [9:0] req_sat_level,
   input wire logic signed [9:0] req_val_level,
   input wire logic [7:0]        req_alpha_in,
   input wire logic              rsp_empty,
   input wire logic              rsp_pop,
   input wire logic [7:0]        rsp_red_out,
   input wire logic [7:0]        rsp_green_out,
   input wire logic [7:0]        rsp_blue_out,
   input wire logic [7:0]        rsp_alpha_out
);

   logic [3:0]  pending_ff;
   logic [3:0]  pending_in;
   logic        in_take;
   logic        out_take;
   logic        rsp_stall;
   logic [32:0] rsp_view;

   // Count items accepted but not yet delivered
   assign in_take  = req_push && !req_full;
   assign out_take = rsp_pop && !rsp_empty;

   // Bundle the result side for the hold check
   assign rsp_stall = !rsp_empty && !rsp_pop;
   assign rsp_view  = {rsp_empty, rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out};

   always_comb begin
      pending_in = pending_ff + {3'd0, in_take} - {3'd0, out_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 4'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `HSV2RGB_ASSERT_RESET(a_reset_clear, rsp_empty && !req_full, "not clear after reset")
   `HSV2RGB_ASSERT(a_no_invented, !rsp_empty, pending_ff != 4'd0, "result with no item pending")
   `HSV2RGB_ASSERT(a_full_backlog, req_full, pending_ff >= 4'd3, "full with short backlog")
   `HSV2RGB_ASSERT_NEXT(a_hold_result, rsp_stall, $stable(rsp_view), "waiting result changed")

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_checker (.*);

`default_nettype wire
